// ===== rtl/ips_pkg.sv =====
// Shared widths, register indexes and reset values for the incremental PID speed block.
package ips_pkg;

    localparam int SPEED_W   = 12;
    localparam int DIFF_W    = 13;
    localparam int ERR_W     = 11;
    localparam int DERR_W    = 12;
    localparam int DDERR_W   = 13;
    localparam int DRV_W     = 13;
    localparam int GAIN_W    = 16;
    localparam int ELIM_W    = 10;
    localparam int OLIM_W    = 12;
    localparam int SUM_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] REG_KP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ELIM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OLIM = 3'd4;

    localparam logic [GAIN_W-1:0] KP_RST   = 16'd3072;
    localparam logic [GAIN_W-1:0] KI_RST   = 16'd230;
    localparam logic [GAIN_W-1:0] KD_RST   = 16'd256;
    localparam logic [ELIM_W-1:0] ELIM_RST = 10'd50;
    localparam logic [OLIM_W-1:0] OLIM_RST = 12'd1000;

endpackage

// ===== rtl/incremental_pid_speed.sv =====
// Incremental (velocity-form) PID speed controller, top level.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  in       | i_in_valid / o_in_ready    | i_target_speed, i_measured_speed
//  out      | o_out_valid / i_out_ready  | o_drive_value
//  cfg      | i_cfg_we                   | i_cfg_idx, i_cfg_wdata
//
//  The path runs through the input register, then the result register.
//  One beat per cycle unless the output stalls; the state feedback (held drive,
//  past errors) closes through the single compute pass between the two registers.
//  Reset restores register defaults and clears the held drive and past errors.
//  A stalled output holds the result; the input register still fills, then stalls.
module incremental_pid_speed #(
    parameter int GAIN_FRAC_BITS = ips_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [ips_pkg::SPEED_W-1:0]     i_target_speed,
    input  logic signed [ips_pkg::SPEED_W-1:0]     i_measured_speed,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [ips_pkg::DRV_W-1:0]       o_drive_value,
    input  logic                                   i_cfg_we,
    input  logic        [ips_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic        [ips_pkg::CFG_DAT_W-1:0]   i_cfg_wdata
);

    localparam int SUM_W = ips_pkg::SUM_W;
    localparam logic [SUM_W-1:0] TRUNC_BIAS =
        SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    // config
    logic [ips_pkg::GAIN_W-1:0] r_kp, r_ki, r_kd;
    logic [ips_pkg::ELIM_W-1:0] r_elim;
    logic [ips_pkg::OLIM_W-1:0] r_olim;

    // input stage
    logic                              r_in_valid;
    logic signed [ips_pkg::SPEED_W-1:0] r_tgt, r_meas;

    // state and result
    logic signed [ips_pkg::DRV_W-1:0]  r_acc;
    logic signed [ips_pkg::ERR_W-1:0]  r_last_err, r_prior_err;
    logic                              r_out_valid;
    logic signed [ips_pkg::DRV_W-1:0]  r_drive;

    logic advance;
    logic in_take;

    logic signed [ips_pkg::DIFF_W-1:0]  diff, elim_s;
    logic signed [ips_pkg::ERR_W-1:0]   err;
    logic signed [ips_pkg::DERR_W-1:0]  derr;
    logic signed [ips_pkg::DDERR_W-1:0] dderr;
    logic signed [ips_pkg::GAIN_W:0]    kp_s, ki_s, kd_s;
    logic signed [SUM_W-1:0]            prod_p, prod_i, prod_d, sum, biased, inc, total, olim_s;
    logic signed [ips_pkg::DRV_W-1:0]   n_acc;

    function automatic logic signed [ips_pkg::DIFF_W-1:0] DIFF_W_ext(
        input logic signed [ips_pkg::SPEED_W-1:0] v
    );
        return ips_pkg::DIFF_W'(v);
    endfunction

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        diff   = DIFF_W_ext(r_tgt) - DIFF_W_ext(r_meas);
        elim_s = $signed({3'b000, r_elim});
        if (diff > elim_s) begin
            err = ips_pkg::ERR_W'(elim_s);
        end else if (diff < -elim_s) begin
            err = ips_pkg::ERR_W'(-elim_s);
        end else begin
            err = ips_pkg::ERR_W'(diff);
        end
        derr  = ips_pkg::DERR_W'(err) - ips_pkg::DERR_W'(r_last_err);
        dderr = ips_pkg::DDERR_W'(err) - (ips_pkg::DDERR_W'(r_last_err) <<< 1)
              + ips_pkg::DDERR_W'(r_prior_err);
        kp_s   = $signed({1'b0, r_kp});
        ki_s   = $signed({1'b0, r_ki});
        kd_s   = $signed({1'b0, r_kd});
        prod_i = ki_s * err;
        prod_p = kp_s * derr;
        prod_d = kd_s * dderr;
        sum    = prod_i + prod_p + prod_d;
        // round toward zero on the fraction drop
        biased = sum + (sum[SUM_W-1] ? $signed(TRUNC_BIAS) : $signed(SUM_W'(0)));
        inc    = biased >>> GAIN_FRAC_BITS;
        total  = SUM_W'(r_acc) + inc;
        olim_s = $signed(SUM_W'(r_olim));
        if (total > olim_s) begin
            n_acc = ips_pkg::DRV_W'(olim_s);
        end else if (total < -olim_s) begin
            n_acc = ips_pkg::DRV_W'(-olim_s);
        end else begin
            n_acc = ips_pkg::DRV_W'(total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= ips_pkg::KP_RST;
            r_ki   <= ips_pkg::KI_RST;
            r_kd   <= ips_pkg::KD_RST;
            r_elim <= ips_pkg::ELIM_RST;
            r_olim <= ips_pkg::OLIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ips_pkg::REG_KP:   r_kp   <= i_cfg_wdata;
                ips_pkg::REG_KI:   r_ki   <= i_cfg_wdata;
                ips_pkg::REG_KD:   r_kd   <= i_cfg_wdata;
                ips_pkg::REG_ELIM: r_elim <= i_cfg_wdata[ips_pkg::ELIM_W-1:0];
                ips_pkg::REG_OLIM: r_olim <= i_cfg_wdata[ips_pkg::OLIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_last_err  <= '0;
            r_prior_err <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_acc       <= n_acc;
                r_prior_err <= r_last_err;
                r_last_err  <= err;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_tgt  <= i_target_speed;
            r_meas <= i_measured_speed;
        end
        if (advance) begin
            r_drive <= n_acc;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_value = r_drive;

`ifndef NO_ASSERTIONS
    a_drive_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_drive_value == r_acc)
        else $error("shown drive differs from held drive");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("computed beat not presented");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && o_out_valid && !i_out_ready))
        else $error("input stalled without a full pipeline");
`endif

endmodule
